### rtl/core/ftpm_pkg.sv
// Package for the flow table packet monitor: sizes, codes, shared structs
// and the port-to-application lookup. No dependencies.

package ftpm_pkg;

  // Flow table geometry.
  localparam int unsigned FLOW_ENTRIES = 256;
  localparam int unsigned FLOW_IDX_W   = $clog2(FLOW_ENTRIES);
  localparam int unsigned FLOW_CNT_W   = $clog2(FLOW_ENTRIES + 1);

  // Field widths of the result.
  localparam int unsigned CLASS_FLOW_W = 9;
  localparam int unsigned BYTE_CNT_W   = 48;
  localparam int unsigned PKT_CNT_W    = 32;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned OUT_USER_W = 2;

  // Protocol numbers and fixed header sizes.
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] ETH_HDR_LEN = 8'd14;
  localparam logic [5:0] UDP_HDR_LEN = 6'd8;

  typedef enum logic [1:0] {
    CLASS_OTHER = 2'd0,
    CLASS_TCP   = 2'd1,
    CLASS_UDP   = 2'd2
  } pkt_class_e;

  typedef enum logic [4:0] {
    APP_UNKNOWN = 5'd0,
    APP_FTP     = 5'd1,
    APP_SSH     = 5'd2,
    APP_TELNET  = 5'd3,
    APP_SMTP    = 5'd4,
    APP_DNS     = 5'd5,
    APP_DHCP    = 5'd6,
    APP_TFTP    = 5'd7,
    APP_HTTP    = 5'd8,
    APP_POP3    = 5'd9,
    APP_NTP     = 5'd10,
    APP_NETBIOS = 5'd11,
    APP_IMAP    = 5'd12,
    APP_SNMP    = 5'd13,
    APP_BGP     = 5'd14,
    APP_LDAP    = 5'd15,
    APP_HTTPS   = 5'd16,
    APP_LDAPS   = 5'd17,
    APP_FTPS    = 5'd18
  } app_e;

  // Which transport a port assignment holds for.
  typedef enum logic [1:0] {
    SCOPE_BOTH = 2'd0,
    SCOPE_TCP  = 2'd1,
    SCOPE_UDP  = 2'd2
  } app_scope_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_PARSE,
    TOP_SEARCH,
    TOP_EMIT
  } top_state_e;

  typedef enum logic {
    SRCH_IDLE,
    SRCH_SCAN
  } srch_state_e;

  // One flow table entry: address pair and port pair with the UDP bit.
  typedef struct packed {
    logic [63:0] addr;
    logic [32:0] ports_kind;
  } flow_key_t;

  // Outcome of one table search.
  typedef struct packed {
    logic done;
    logic found;
    logic stored;
    logic full;
  } srch_res_t;

  // Per-packet header results.
  typedef struct packed {
    pkt_class_e  pkt_class;
    logic [5:0]  header_len;
    logic [15:0] payload_len;
    logic        short_cap;
    app_e        src_app;
    app_e        dst_app;
  } hdr_info_t;

  // Maps a port number to its application code for the given transport.
  function automatic app_e app_code(input logic [15:0] port, input logic is_tcp);
    app_e       code;
    app_scope_e scope;
    code  = APP_UNKNOWN;
    scope = SCOPE_BOTH;
    unique case (port)
      16'd20, 16'd21: begin code = APP_FTP; scope = SCOPE_TCP; end
      16'd22: begin code = APP_SSH; scope = SCOPE_TCP; end
      16'd23: begin code = APP_TELNET; scope = SCOPE_TCP; end
      16'd25: begin code = APP_SMTP; scope = SCOPE_TCP; end
      16'd53: begin code = APP_DNS; end
      16'd67, 16'd68: begin code = APP_DHCP; scope = SCOPE_UDP; end
      16'd69: begin code = APP_TFTP; scope = SCOPE_UDP; end
      16'd80: begin code = APP_HTTP; scope = SCOPE_TCP; end
      16'd110: begin code = APP_POP3; scope = SCOPE_TCP; end
      16'd123: begin code = APP_NTP; scope = SCOPE_UDP; end
      16'd137, 16'd138, 16'd139: begin code = APP_NETBIOS; end
      16'd143: begin code = APP_IMAP; scope = SCOPE_TCP; end
      16'd161, 16'd162: begin code = APP_SNMP; end
      16'd179: begin code = APP_BGP; scope = SCOPE_TCP; end
      16'd389: begin code = APP_LDAP; end
      16'd443, 16'd8443: begin code = APP_HTTPS; scope = SCOPE_TCP; end
      16'd636: begin code = APP_LDAPS; end
      16'd989, 16'd990: begin code = APP_FTPS; scope = SCOPE_TCP; end
      default: begin code = APP_UNKNOWN; end
    endcase
    if ((scope == SCOPE_TCP && !is_tcp) || (scope == SCOPE_UDP && is_tcp)) begin
      code = APP_UNKNOWN;
    end
    return code;
  endfunction

endpackage

### rtl/core/ftpm_hdr_calc.sv
// Parse stage: classifies the packet, works out header and payload lengths,
// maps ports to applications and builds the flow key. Depends on ftpm_pkg.

module ftpm_hdr_calc (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  input  logic [15:0]         sport_i,
  input  logic [15:0]         dport_i,
  input  logic [7:0]          ip_protocol_i,
  input  logic [15:0]         captured_length_i,
  input  logic [3:0]          ip_header_words_i,
  input  logic [3:0]          tcp_data_offset_i,
  output ftpm_pkg::hdr_info_t hdr_o,
  output ftpm_pkg::flow_key_t key_o
);
  import ftpm_pkg::*;

  logic       is_tcp;
  logic       is_udp;
  logic [5:0] hdr_len;
  logic [7:0] overhead;
  hdr_info_t  hdr_d, hdr_q;
  flow_key_t  key_d, key_q;

  assign is_tcp   = (ip_protocol_i == PROTO_TCP);
  assign is_udp   = (ip_protocol_i == PROTO_UDP);
  assign hdr_len  = is_tcp ? {tcp_data_offset_i, 2'b00} : UDP_HDR_LEN;
  // Ethernet, IP and transport headers together.
  assign overhead = ETH_HDR_LEN + {2'b00, ip_header_words_i, 2'b00} + {2'b00, hdr_len};

  // Header results; everything stays zero for other protocols.
  always_comb begin
    hdr_d = '0;
    if (is_tcp || is_udp) begin
      hdr_d.pkt_class  = is_tcp ? CLASS_TCP : CLASS_UDP;
      hdr_d.header_len = hdr_len;
      if (captured_length_i >= {8'd0, overhead}) begin
        hdr_d.payload_len = captured_length_i - {8'd0, overhead};
      end else begin
        hdr_d.short_cap = 1'b1;
      end
      hdr_d.src_app = app_code(sport_i, is_tcp);
      hdr_d.dst_app = app_code(dport_i, is_tcp);
    end
  end

  // Flow key as stored in the table.
  assign key_d.addr       = {src_addr_i, dst_addr_i};
  assign key_d.ports_kind = {sport_i, dport_i, is_udp};

  // Payload registers, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hdr_q <= hdr_d;
      key_q <= key_d;
    end
  end

  assign hdr_o = hdr_q;
  assign key_o = key_q;

endmodule

### rtl/core/ftpm_flow_search.sv
// Flow table: a synchronous memory of five-tuples with a linear search
// sequencer and the fill count. Depends on ftpm_pkg.

module ftpm_flow_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ftpm_pkg::flow_key_t key_i,
  output ftpm_pkg::srch_res_t res_o
);
  import ftpm_pkg::*;

  srch_state_e           state_q, state_d;
  logic [FLOW_CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [FLOW_CNT_W-1:0] fill_q, fill_d;
  logic                  pend_q, pend_d;
  flow_key_t             key_q;
  flow_key_t             rd_data_q;
  flow_key_t             mem [FLOW_ENTRIES];
  logic                  rd_en;
  logic                  wr_en;
  logic                  hit;
  logic                  miss;
  logic                  room;

  // Only filled entries are ever read, and the insert goes to the first
  // unfilled one, so a read and a write never meet on the same entry.
  assign rd_en = (state_q == SRCH_SCAN) && (rd_idx_q < fill_q);
  assign hit   = (state_q == SRCH_SCAN) && pend_q && (rd_data_q == key_q);
  assign miss  = (state_q == SRCH_SCAN) && !pend_q && !rd_en;
  assign room  = (fill_q < FLOW_CNT_W'(FLOW_ENTRIES));
  assign wr_en = miss && room;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SRCH_IDLE: if (start_i) state_d = SRCH_SCAN;
      SRCH_SCAN: if (hit || miss) state_d = SRCH_IDLE;
      default:   state_d = SRCH_IDLE;
    endcase
  end

  // Scan pointer, read-pending flag and fill count.
  always_comb begin
    rd_idx_d = rd_idx_q;
    pend_d   = 1'b0;
    fill_d   = fill_q;
    if (state_q == SRCH_IDLE) begin
      rd_idx_d = '0;
    end else begin
      pend_d = rd_en;
      if (rd_en) rd_idx_d = rd_idx_q + 1'b1;
    end
    if (wr_en) fill_d = fill_q + 1'b1;
  end

  // Search outcome.
  always_comb begin
    res_o        = '0;
    res_o.done   = hit || miss;
    res_o.found  = hit;
    res_o.stored = wr_en;
    res_o.full   = miss && !room;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SRCH_IDLE;
      rd_idx_q <= '0;
      fill_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      fill_q   <= fill_d;
      pend_q   <= pend_d;
    end
  end

  // Search key, held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (state_q == SRCH_IDLE && start_i) key_q <= key_i;
  end

  // Table memory: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem[rd_idx_q[FLOW_IDX_W-1:0]];
    if (wr_en) mem[fill_q[FLOW_IDX_W-1:0]] <= key_q;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FLOW_CNT_W'(FLOW_ENTRIES))
    else $error("flow table fill count beyond capacity");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> $countones({res_o.found, res_o.stored, res_o.full}) == 1)
    else $error("search finished with no single outcome");

  a_store_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.stored |=> fill_q == $past(fill_q) + 1'b1)
    else $error("stored flow did not advance the fill count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> rd_idx_q <= fill_q)
    else $error("scan pointer ran past the filled entries");

endmodule

### rtl/core/flow_table_packet_monitor.sv
// Top level of the flow table packet monitor: stream ports, control sequencer,
// traffic counters and output register. Uses ftpm_pkg, ftpm_hdr_calc and
// ftpm_flow_search.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one parsed packet header per transaction
//   m_axis    out        one result per packet, packet class in tuser
//
// One packet at a time. A TCP or UDP packet is searched against the flows
// stored (up to 256): the table memory is read one entry per cycle. Other
// packets skip the search. After reset the table is empty and every counter
// is zero; no clearing pass is needed. A stalled output holds its result
// while the next packet is already taken in and worked on.

module flow_table_packet_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // src_addr, dst_addr, sport, dport, ip_protocol, captured_length,
  // ip_header_words, tcp_data_offset
  input  logic [ftpm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // header_length, payload_length, short_capture, new_flow, table_full,
  // src_app, dst_app, total_packet_count, class_packet_count,
  // class_byte_count, class_flow_count, 4 zero bits
  output logic [ftpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // packet_class
  output logic [ftpm_pkg::OUT_USER_W-1:0]   m_axis_tuser_o
);
  import ftpm_pkg::*;

  top_state_e            state_q, state_d;
  hdr_info_t             hdr;
  flow_key_t             key;
  srch_res_t             srch_res;
  logic                  in_fire;
  logic                  srch_start;
  logic                  out_free;
  logic                  out_load;
  logic                  stored_q, full_q;
  logic [PKT_CNT_W-1:0]  total_q, tcp_pkts_q, udp_pkts_q;
  logic [PKT_CNT_W-1:0]  total_d, tcp_pkts_d, udp_pkts_d;
  logic [BYTE_CNT_W-1:0] tcp_bytes_q, udp_bytes_q, tcp_bytes_d, udp_bytes_d;
  logic [FLOW_CNT_W-1:0] tcp_flows_q, udp_flows_q, tcp_flows_d, udp_flows_d;
  logic [BYTE_CNT_W-1:0] pkt_bytes;
  logic                  is_tcp, is_udp;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_USER_W-1:0] out_user_q;
  logic [PKT_CNT_W-1:0]  cls_pkts;
  logic [BYTE_CNT_W-1:0] cls_bytes;
  logic [CLASS_FLOW_W-1:0] cls_flows;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign is_tcp     = (hdr.pkt_class == CLASS_TCP);
  assign is_udp     = (hdr.pkt_class == CLASS_UDP);

  ftpm_hdr_calc u_hdr_calc (
    .clk_i             (clk_i),
    .load_i            (in_fire),
    .src_addr_i        (s_axis_tdata_i[31:0]),
    .dst_addr_i        (s_axis_tdata_i[63:32]),
    .sport_i           (s_axis_tdata_i[79:64]),
    .dport_i           (s_axis_tdata_i[95:80]),
    .ip_protocol_i     (s_axis_tdata_i[103:96]),
    .captured_length_i (s_axis_tdata_i[119:104]),
    .ip_header_words_i (s_axis_tdata_i[123:120]),
    .tcp_data_offset_i (s_axis_tdata_i[127:124]),
    .hdr_o             (hdr),
    .key_o             (key)
  );

  ftpm_flow_search u_flow_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .key_i   (key),
    .res_o   (srch_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TOP_IDLE:   if (in_fire) state_d = TOP_PARSE;
      TOP_PARSE:  state_d = (is_tcp || is_udp) ? TOP_SEARCH : TOP_EMIT;
      TOP_SEARCH: if (srch_res.done) state_d = TOP_EMIT;
      TOP_EMIT:   if (out_free) state_d = TOP_IDLE;
      default:    state_d = TOP_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = (state_q == TOP_IDLE);
    srch_start      = (state_q == TOP_PARSE) && (is_tcp || is_udp);
    out_load        = (state_q == TOP_EMIT) && out_free;
  end

  // Counter updates, committed when the result is loaded.
  assign pkt_bytes = BYTE_CNT_W'(hdr.header_len) + BYTE_CNT_W'(hdr.payload_len);

  always_comb begin
    total_d     = total_q + 1'b1;
    tcp_pkts_d  = tcp_pkts_q;
    udp_pkts_d  = udp_pkts_q;
    tcp_bytes_d = tcp_bytes_q;
    udp_bytes_d = udp_bytes_q;
    tcp_flows_d = tcp_flows_q;
    udp_flows_d = udp_flows_q;
    if (is_tcp) begin
      tcp_pkts_d  = tcp_pkts_q + 1'b1;
      tcp_bytes_d = tcp_bytes_q + pkt_bytes;
      if (stored_q) tcp_flows_d = tcp_flows_q + 1'b1;
    end
    if (is_udp) begin
      udp_pkts_d  = udp_pkts_q + 1'b1;
      udp_bytes_d = udp_bytes_q + pkt_bytes;
      if (stored_q) udp_flows_d = udp_flows_q + 1'b1;
    end
  end

  // Class counters for the result; zero for other protocols.
  always_comb begin
    cls_pkts  = '0;
    cls_bytes = '0;
    cls_flows = '0;
    if (is_tcp) begin
      cls_pkts  = tcp_pkts_d;
      cls_bytes = tcp_bytes_d;
      cls_flows = CLASS_FLOW_W'(tcp_flows_d);
    end else if (is_udp) begin
      cls_pkts  = udp_pkts_d;
      cls_bytes = udp_bytes_d;
      cls_flows = CLASS_FLOW_W'(udp_flows_d);
    end
  end

  // Result packing.
  assign out_data_d = {4'b0000, cls_flows, cls_bytes, cls_pkts, total_d,
                       hdr.dst_app, hdr.src_app, full_q, stored_q,
                       hdr.short_cap, hdr.payload_len, hdr.header_len};

  // Control registers and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      stored_q    <= 1'b0;
      full_q      <= 1'b0;
      total_q     <= '0;
      tcp_pkts_q  <= '0;
      udp_pkts_q  <= '0;
      tcp_bytes_q <= '0;
      udp_bytes_q <= '0;
      tcp_flows_q <= '0;
      udp_flows_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == TOP_PARSE) begin
        stored_q <= 1'b0;
        full_q   <= 1'b0;
      end else if (srch_res.done) begin
        stored_q <= srch_res.stored;
        full_q   <= srch_res.full;
      end
      if (out_load) begin
        total_q     <= total_d;
        tcp_pkts_q  <= tcp_pkts_d;
        udp_pkts_q  <= udp_pkts_d;
        tcp_bytes_q <= tcp_bytes_d;
        udp_bytes_q <= udp_bytes_d;
        tcp_flows_q <= tcp_flows_d;
        udp_flows_q <= udp_flows_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= hdr.pkt_class;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  a_other_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == CLASS_OTHER |-> m_axis_tdata_o[34:0] == '0)
    else $error("result for other protocol carries header or flow fields");

  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> state_q == TOP_SEARCH)
    else $error("search finished outside the search state");

  a_total_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> total_q == $past(total_q) + 1'b1)
    else $error("packet total did not advance with a result");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[23] && m_axis_tdata_o[24]))
    else $error("new flow and table full raised together");

endmodule
